/* hw/rtl/cbrf_pkg.sv */
`default_nettype none

package cbrf_pkg;

   localparam int WORD_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int MAX_STEPS      = 64;
   localparam int PROD_WIDTH     = 2 * WORD_WIDTH;
   localparam int TOL_WIDTH      = WORD_WIDTH - 1;
   localparam int LIMIT_WIDTH    = 7;
   localparam int STEPS_WIDTH    = 7;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int PC_WIDTH       = 4;

   localparam logic [TOL_WIDTH-1:0]   TOL_RESET   = TOL_WIDTH'(6554);
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(32);

   typedef logic [PC_WIDTH-1:0] pc_type;

   localparam pc_type PC_WAIT = PC_WIDTH'(0);
   localparam pc_type PC_LOOP = PC_WIDTH'(8);
   localparam pc_type PC_TEST = PC_WIDTH'(14);

   typedef enum logic [2:0] {
      REG_COEF_CUBIC    = 3'd0,
      REG_COEF_SQUARE   = 3'd1,
      REG_COEF_LINEAR   = 3'd2,
      REG_COEF_CONSTANT = 3'd3,
      REG_TOLERANCE     = 3'd4,
      REG_ITER_LIMIT    = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_MUL,
      OP_ADD,
      OP_SIGN,
      OP_TEST
   } op_type;

   typedef enum logic [1:0] {
      CSEL_SQUARE,
      CSEL_LINEAR,
      CSEL_CONSTANT
   } csel_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_HOLD,
      JMP_LOOP,
      JMP_GOTO
   } jmp_type;

   typedef enum logic [1:0] {
      OUT_TOLERANCE  = 2'd0,
      OUT_EXACT_ZERO = 2'd1,
      OUT_LIMIT      = 2'd2
   } outcome_type;

   typedef struct packed {
      op_type   op;
      csel_type csel;
      jmp_type  jmp;
      pc_type   target;
   } uword_type;

   typedef struct packed {
      op_type   op;
      csel_type csel;
      logic     go;
   } dp_ctrl_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] coef_cubic;
      logic signed [WORD_WIDTH-1:0] coef_square;
      logic signed [WORD_WIDTH-1:0] coef_linear;
      logic signed [WORD_WIDTH-1:0] coef_constant;
      logic [TOL_WIDTH-1:0]         tolerance;
      logic [LIMIT_WIDTH-1:0]       iteration_limit;
   } cfg_type;

   function automatic uword_type mk_uword(input op_type op, input csel_type csel,
                                          input jmp_type jmp, input pc_type target);
      uword_type w;
      w.op     = op;
      w.csel   = csel;
      w.jmp    = jmp;
      w.target = target;
      return w;
   endfunction

   // Program: evaluate f(low) once, then loop midpoint evaluations.
   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      case (pc)
         4'd0:    w = mk_uword(OP_WAIT, CSEL_SQUARE,   JMP_HOLD, PC_WAIT);
         4'd1:    w = mk_uword(OP_MUL,  CSEL_SQUARE,   JMP_NEXT, PC_WAIT);
         4'd2:    w = mk_uword(OP_ADD,  CSEL_SQUARE,   JMP_NEXT, PC_WAIT);
         4'd3:    w = mk_uword(OP_MUL,  CSEL_LINEAR,   JMP_NEXT, PC_WAIT);
         4'd4:    w = mk_uword(OP_ADD,  CSEL_LINEAR,   JMP_NEXT, PC_WAIT);
         4'd5:    w = mk_uword(OP_MUL,  CSEL_CONSTANT, JMP_NEXT, PC_WAIT);
         4'd6:    w = mk_uword(OP_ADD,  CSEL_CONSTANT, JMP_NEXT, PC_WAIT);
         4'd7:    w = mk_uword(OP_SIGN, CSEL_SQUARE,   JMP_NEXT, PC_WAIT);
         4'd8:    w = mk_uword(OP_MUL,  CSEL_SQUARE,   JMP_NEXT, PC_WAIT);
         4'd9:    w = mk_uword(OP_ADD,  CSEL_SQUARE,   JMP_NEXT, PC_WAIT);
         4'd10:   w = mk_uword(OP_MUL,  CSEL_LINEAR,   JMP_NEXT, PC_WAIT);
         4'd11:   w = mk_uword(OP_ADD,  CSEL_LINEAR,   JMP_NEXT, PC_WAIT);
         4'd12:   w = mk_uword(OP_MUL,  CSEL_CONSTANT, JMP_NEXT, PC_WAIT);
         4'd13:   w = mk_uword(OP_ADD,  CSEL_CONSTANT, JMP_NEXT, PC_WAIT);
         4'd14:   w = mk_uword(OP_TEST, CSEL_SQUARE,   JMP_LOOP, PC_LOOP);
         default: w = mk_uword(OP_WAIT, CSEL_SQUARE,   JMP_GOTO, PC_WAIT);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/cbrf_csr.sv */
`default_nettype none

module cbrf_csr
   import cbrf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready,
   output cfg_type                        cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel = csr_reg_type'(paddr[4:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_COEF_CUBIC:    cfg_in.coef_cubic    = pwdata[WORD_WIDTH-1:0];
            REG_COEF_SQUARE:   cfg_in.coef_square   = pwdata[WORD_WIDTH-1:0];
            REG_COEF_LINEAR:   cfg_in.coef_linear   = pwdata[WORD_WIDTH-1:0];
            REG_COEF_CONSTANT: cfg_in.coef_constant = pwdata[WORD_WIDTH-1:0];
            REG_TOLERANCE:     cfg_in.tolerance     = pwdata[TOL_WIDTH-1:0];
            REG_ITER_LIMIT:    cfg_in.iteration_limit = pwdata[LIMIT_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_COEF_CUBIC:    prdata = cfg_ff.coef_cubic;
         REG_COEF_SQUARE:   prdata = cfg_ff.coef_square;
         REG_COEF_LINEAR:   prdata = cfg_ff.coef_linear;
         REG_COEF_CONSTANT: prdata = cfg_ff.coef_constant;
         REG_TOLERANCE:     prdata = CSR_DATA_WIDTH'(cfg_ff.tolerance);
         REG_ITER_LIMIT:    prdata = CSR_DATA_WIDTH'(cfg_ff.iteration_limit);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_cubic      <= '0;
         cfg_ff.coef_square     <= '0;
         cfg_ff.coef_linear     <= '0;
         cfg_ff.coef_constant   <= '0;
         cfg_ff.tolerance       <= TOL_RESET;
         cfg_ff.iteration_limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/cbrf_seq.sv */
`default_nettype none

module cbrf_seq
   import cbrf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   input  wire logic  stop,
   output logic       busy,
   output dp_ctrl_type ctrl
);

   pc_type    pc_ff;
   pc_type    pc_in;
   uword_type uw;

   assign uw        = ucode_rom(pc_ff);
   assign busy      = (uw.op != OP_WAIT);
   assign ctrl.op   = uw.op;
   assign ctrl.csel = uw.csel;
   assign ctrl.go   = (uw.op == OP_WAIT) && start;

   always_comb begin
      case (uw.jmp)
         JMP_NEXT: pc_in = pc_ff + PC_WIDTH'(1);
         JMP_HOLD: pc_in = start ? pc_ff + PC_WIDTH'(1) : pc_ff;
         JMP_LOOP: pc_in = stop ? PC_WAIT : uw.target;
         JMP_GOTO: pc_in = uw.target;
         default:  pc_in = PC_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start the program");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_TEST)
      else $error("step counter left the program");

endmodule

`default_nettype wire

/* hw/rtl/cbrf_datapath.sv */
`default_nettype none

module cbrf_datapath
   import cbrf_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dp_ctrl_type                  ctrl,
   input  wire cfg_type                      cfg,
   input  wire logic signed [WORD_WIDTH-1:0] req_interval_low,
   input  wire logic signed [WORD_WIDTH-1:0] req_interval_high,
   output logic                              stop,
   output logic                              rsp_valid,
   output logic signed [WORD_WIDTH-1:0]      rsp_root_estimate,
   output logic [STEPS_WIDTH-1:0]            rsp_steps_taken,
   output logic [1:0]                        rsp_outcome
);

   localparam logic signed [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic signed [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   logic signed [WORD_WIDTH-1:0] lo_ff, lo_in, hi_ff, hi_in, x_ff, x_in, acc_ff, acc_in;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic                         low_neg_ff, low_neg_in;
   logic [STEPS_WIDTH-1:0]       steps_ff, steps_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_WIDTH-1:0] root_ff, root_in;
   logic [STEPS_WIDTH-1:0]       rsp_steps_ff, rsp_steps_in;
   outcome_type                  outcome_ff, outcome_in;

   logic signed [PROD_WIDTH-1:0]   shifted;
   logic [PROD_WIDTH-WORD_WIDTH:0] prod_top;
   logic signed [WORD_WIDTH-1:0]   prod_sat;
   logic signed [WORD_WIDTH-1:0]   coef_sel;
   logic signed [WORD_WIDTH:0]     sum_wide;
   logic signed [WORD_WIDTH-1:0]   add_sat;
   logic [WORD_WIDTH-1:0]          acc_mag;
   logic [LIMIT_WIDTH-1:0]         limit_eff;
   logic                           is_zero, in_tol, at_limit, acc_neg;
   logic signed [WORD_WIDTH-1:0]   lo_next, hi_next, mid_a, mid_b;
   logic signed [WORD_WIDTH:0]     mid_sum;
   logic signed [WORD_WIDTH-1:0]   mid;

   // product: floor shift by the fraction bits, then clamp to the word range
   assign prod_in  = PROD_WIDTH'(acc_ff) * PROD_WIDTH'(x_ff);
   assign shifted  = prod_ff >>> FRAC_BITS;
   assign prod_top = shifted[PROD_WIDTH-1:WORD_WIDTH-1];
   assign prod_sat = ((&prod_top) || !(|prod_top)) ? shifted[WORD_WIDTH-1:0]
                   : (shifted[PROD_WIDTH-1] ? WMIN : WMAX);

   always_comb begin
      case (ctrl.csel)
         CSEL_SQUARE:   coef_sel = cfg.coef_square;
         CSEL_LINEAR:   coef_sel = cfg.coef_linear;
         CSEL_CONSTANT: coef_sel = cfg.coef_constant;
         default:       coef_sel = cfg.coef_constant;
      endcase
   end

   assign sum_wide = (WORD_WIDTH+1)'(prod_sat) + (WORD_WIDTH+1)'(coef_sel);
   assign add_sat  = (sum_wide[WORD_WIDTH] == sum_wide[WORD_WIDTH-1])
                   ? sum_wide[WORD_WIDTH-1:0]
                   : (sum_wide[WORD_WIDTH] ? WMIN : WMAX);

   // termination checks on f(mid) in acc
   assign acc_neg  = acc_ff[WORD_WIDTH-1];
   assign acc_mag  = acc_neg ? (WORD_WIDTH)'(-acc_ff) : acc_ff;
   assign is_zero  = (acc_ff == '0);
   assign in_tol   = (acc_mag < {1'b0, cfg.tolerance});

   always_comb begin
      if (cfg.iteration_limit == '0) begin
         limit_eff = LIMIT_WIDTH'(1);
      end else if (cfg.iteration_limit > LIMIT_WIDTH'(MAX_STEPS)) begin
         limit_eff = LIMIT_WIDTH'(MAX_STEPS);
      end else begin
         limit_eff = cfg.iteration_limit;
      end
   end

   assign at_limit = (LIMIT_WIDTH'(steps_ff) >= limit_eff);
   assign stop     = is_zero || in_tol || at_limit;

   // keep the half whose ends differ in sign
   assign lo_next = (acc_neg == low_neg_ff) ? x_ff : lo_ff;
   assign hi_next = (acc_neg == low_neg_ff) ? hi_ff : x_ff;
   assign mid_a   = (ctrl.op == OP_TEST) ? lo_next : lo_ff;
   assign mid_b   = (ctrl.op == OP_TEST) ? hi_next : hi_ff;
   assign mid_sum = (WORD_WIDTH+1)'(mid_a) + (WORD_WIDTH+1)'(mid_b);
   assign mid     = mid_sum[WORD_WIDTH:1];

   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      low_neg_in   = low_neg_ff;
      steps_in     = steps_ff;
      rsp_valid_in = 1'b0;
      root_in      = root_ff;
      rsp_steps_in = rsp_steps_ff;
      outcome_in   = outcome_ff;
      case (ctrl.op)
         OP_WAIT: begin
            if (ctrl.go) begin
               lo_in    = req_interval_low;
               hi_in    = req_interval_high;
               x_in     = req_interval_low;
               acc_in   = cfg.coef_cubic;
               steps_in = '0;
            end
         end
         OP_MUL: begin
         end
         OP_ADD: begin
            acc_in = add_sat;
         end
         OP_SIGN: begin
            low_neg_in = acc_neg;
            x_in       = mid;
            acc_in     = cfg.coef_cubic;
            steps_in   = STEPS_WIDTH'(1);
         end
         OP_TEST: begin
            if (stop) begin
               rsp_valid_in = 1'b1;
               root_in      = x_ff;
               rsp_steps_in = steps_ff;
               if (is_zero) begin
                  outcome_in = OUT_EXACT_ZERO;
               end else if (in_tol) begin
                  outcome_in = OUT_TOLERANCE;
               end else begin
                  outcome_in = OUT_LIMIT;
               end
            end else begin
               lo_in    = lo_next;
               hi_in    = hi_next;
               x_in     = mid;
               acc_in   = cfg.coef_cubic;
               steps_in = steps_ff + STEPS_WIDTH'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      x_ff         <= x_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      low_neg_ff   <= low_neg_in;
      steps_ff     <= steps_in;
      root_ff      <= root_in;
      rsp_steps_ff <= rsp_steps_in;
      outcome_ff   <= outcome_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_root_estimate = root_ff;
   assign rsp_steps_taken   = rsp_steps_ff;
   assign rsp_outcome       = outcome_ff;

   a_steps_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_steps_ff != '0 && rsp_steps_ff <= STEPS_WIDTH'(MAX_STEPS)))
      else $error("reported step count out of range");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ctrl.op == OP_WAIT)
      else $error("result strobe while program still running");

endmodule

`default_nettype wire

/* hw/rtl/cubic_bisection_root_finder_top.sv */
// After the accepting edge the program evaluates f(low), then N midpoint evaluations
// (N = 1..64) before the result strobe; each evaluation is a Horner pass on the one
// shared multiplier. No new transaction is accepted until the strobe; busy is high meanwhile.
// The receiver cannot stall: rsp_valid is high for exactly one cycle per transaction.
// Reset (synchronous, active high) returns the sequencer to idle and loads the
// register defaults: coefficients 0, tolerance 6554, iteration limit 32.
`default_nettype none

module cubic_bisection_root_finder_top
   import cbrf_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [WORD_WIDTH-1:0] req_interval_low,
   input  wire logic signed [WORD_WIDTH-1:0] req_interval_high,
   output logic                              rsp_valid,
   output logic signed [WORD_WIDTH-1:0]      rsp_root_estimate,
   output logic [STEPS_WIDTH-1:0]            rsp_steps_taken,
   output logic [1:0]                        rsp_outcome,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0]    paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [CSR_DATA_WIDTH-1:0]         prdata,
   output logic                              pready
);

   cfg_type     cfg;
   dp_ctrl_type ctrl;
   logic        stop;

   cbrf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cbrf_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stop  (stop),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   cbrf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .cfg               (cfg),
      .req_interval_low  (req_interval_low),
      .req_interval_high (req_interval_high),
      .stop              (stop),
      .rsp_valid         (rsp_valid),
      .rsp_root_estimate (rsp_root_estimate),
      .rsp_steps_taken   (rsp_steps_taken),
      .rsp_outcome       (rsp_outcome)
   );

endmodule

`default_nettype wire
